[sv/ile_pkg.sv]
// Shared types and constants for the indexed list engine.
package ile_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int POS_W           = 6;

  localparam logic [6:0] NONE_IDX = 7'h7F;

  typedef enum logic [3:0] {
    K_APPEND       = 4'd0,
    K_INSERT       = 4'd1,
    K_GET          = 4'd2,
    K_SET          = 4'd3,
    K_REMOVE_AT    = 4'd4,
    K_REMOVE_VALUE = 4'd5,
    K_FIRST_INDEX  = 4'd6,
    K_LAST_INDEX   = 4'd7,
    K_CONTAINS     = 4'd8,
    K_CLEAR        = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } act_t;

  typedef struct packed {
    act_t act;
    logic capture;
  } cell_ctl_t;

endpackage

[sv/indexed_list_engine.sv]
// Top level of the indexed list engine: command control and the row of cells.
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------------------
//  command   | start / busy       | kind, position, item_value
//  result    | done (one cycle)   | status, read_value, found_index, found,
//            |                    | item_count, empty_res
//
// After the accepting edge every command passes S_MATCH, where all cells compare against
// the key and the addressed cell is read, and S_EXEC, where the hit index is encoded and
// the row shifts or is written; done is registered in S_EXEC and is high back in S_IDLE.
// busy is high in both states, so a new command may be accepted in the cycle that
// done is high. The result receiver cannot stall the engine.
// Synchronous reset empties the list; entries are not cleared and need no sweep.
module indexed_list_engine #(
  parameter int CAPACITY    = ile_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = ile_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         kind,
  input  logic [5:0]         position,
  input  logic [31:0]        item_value,
  output logic               done,
  output logic [1:0]         status,
  output logic [31:0]        read_value,
  output logic signed [6:0]  found_index,
  output logic               found,
  output logic [6:0]         item_count,
  output logic               empty_res
);
  import ile_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_EXEC} state_t;

  state_t                 state;
  logic [3:0]             kind_q;
  logic [POS_W-1:0]       pos_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [VALUE_WIDTH-1:0] rd_q;
  logic [CNT_W-1:0]       count;

  logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic [VALUE_WIDTH-1:0] sel_value  [CAPACITY];
  logic [CAPACITY-1:0]    match_vec;
  cell_ctl_t              ctl;
  logic [IDX_W-1:0]       pivot;

  logic [VALUE_WIDTH-1:0] rd_or;
  logic [CAPACITY-1:0]    first_oh, rev_vec, last_oh;
  logic [IDX_W-1:0]       first_idx, last_idx, hit_idx;
  logic                   hit_any, pos_ok, full;

  act_t                   act;
  logic [IDX_W-1:0]       ex_pivot;
  status_t                status_n;
  logic [VALUE_WIDTH-1:0] rd_n;
  logic [6:0]             fidx_n;
  logic                   found_n;
  logic [CNT_W-1:0]       count_n;

  assign busy = (state != S_IDLE);

  assign ctl   = '{act: (state == S_EXEC) ? act : ACT_HOLD, capture: (state == S_MATCH)};
  assign pivot = (state == S_EXEC) ? ex_pivot : IDX_W'(pos_q);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_v, next_v;
    if (g == 0) begin : g_head
      assign prev_v = '0;
    end else begin : g_mid_p
      assign prev_v = cell_value[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign next_v = '0;
    end else begin : g_mid_n
      assign next_v = cell_value[g+1];
    end
    ile_cell #(
      .IDX(g), .VALUE_WIDTH(VALUE_WIDTH), .IDX_W(IDX_W), .CNT_W(CNT_W)
    ) u_cell (
      .clk(clk), .ctl(ctl), .pivot(pivot), .key(val_q),
      .prev_value(prev_v), .next_value(next_v), .count(count),
      .value(cell_value[g]), .sel_value(sel_value[g]), .match(match_vec[g])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) rd_or |= sel_value[i];
  end

  // Lowest set bit isolates the first match; the reversed vector gives the last.
  always_comb begin
    first_oh  = match_vec & (~match_vec + CAPACITY'(1));
    for (int i = 0; i < CAPACITY; i++) rev_vec[i] = match_vec[CAPACITY-1-i];
    last_oh   = rev_vec & (~rev_vec + CAPACITY'(1));
    first_idx = '0;
    last_idx  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_oh[i]) first_idx |= IDX_W'(i);
      if (last_oh[i])  last_idx  |= IDX_W'(CAPACITY - 1 - i);
    end
  end

  assign hit_any = |match_vec;
  assign hit_idx = (kind_q == K_LAST_INDEX) ? last_idx : first_idx;
  assign pos_ok  = CMP_W'(pos_q) < CMP_W'(count);
  assign full    = (count == CNT_W'(CAPACITY));

  always_comb begin
    act      = ACT_HOLD;
    ex_pivot = '0;
    status_n = ST_OK;
    rd_n     = '0;
    fidx_n   = NONE_IDX;
    found_n  = 1'b0;
    count_n  = count;
    unique case (kind_t'(kind_q))
      K_APPEND: begin
        if (full) begin
          status_n = ST_FULL;
        end else begin
          act      = ACT_WRITE;
          ex_pivot = IDX_W'(count);
          count_n  = count + CNT_W'(1);
        end
      end
      K_INSERT: begin
        if (!pos_ok) begin
          status_n = ST_RANGE;
        end else if (full) begin
          status_n = ST_FULL;
        end else begin
          act      = ACT_INSERT;
          ex_pivot = IDX_W'(pos_q);
          count_n  = count + CNT_W'(1);
        end
      end
      K_GET: begin
        if (!pos_ok) status_n = ST_RANGE;
        else rd_n = rd_q;
      end
      K_SET: begin
        if (!pos_ok) begin
          status_n = ST_RANGE;
        end else begin
          act      = ACT_WRITE;
          ex_pivot = IDX_W'(pos_q);
        end
      end
      K_REMOVE_AT: begin
        if (!pos_ok) begin
          status_n = ST_RANGE;
        end else begin
          act      = ACT_REMOVE;
          ex_pivot = IDX_W'(pos_q);
          rd_n     = rd_q;
          count_n  = count - CNT_W'(1);
        end
      end
      K_REMOVE_VALUE, K_FIRST_INDEX, K_LAST_INDEX, K_CONTAINS: begin
        if (hit_any) begin
          found_n = 1'b1;
          fidx_n  = 7'(hit_idx);
          if (kind_q == K_REMOVE_VALUE) begin
            act      = ACT_REMOVE;
            ex_pivot = hit_idx;
            rd_n     = val_q;
            count_n  = count - CNT_W'(1);
          end
        end else if (kind_q != K_CONTAINS) begin
          status_n = ST_NOT_FOUND;
        end
      end
      K_CLEAR: begin
        count_n = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            kind_q <= kind;
            pos_q  <= position;
            val_q  <= VALUE_WIDTH'(item_value);
            state  <= S_MATCH;
          end
        end
        S_MATCH: begin
          rd_q  <= rd_or;
          state <= S_EXEC;
        end
        S_EXEC: begin
          count       <= count_n;
          status      <= status_n;
          read_value  <= 32'(rd_n);
          found_index <= fidx_n;
          found       <= found_n;
          item_count  <= 7'(count_n);
          empty_res   <= (count_n == '0);
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/ile_cell.sv]
// One list cell: holds an entry, shifts with its neighbors and compares against the key.
module ile_cell #(
  parameter int IDX         = 0,
  parameter int VALUE_WIDTH = ile_pkg::VALUE_WIDTH_DEF,
  parameter int IDX_W       = 6,
  parameter int CNT_W       = 7
) (
  input  logic                   clk,
  input  ile_pkg::cell_ctl_t     ctl,
  input  logic [IDX_W-1:0]       pivot,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [VALUE_WIDTH-1:0] prev_value,
  input  logic [VALUE_WIDTH-1:0] next_value,
  input  logic [CNT_W-1:0]       count,
  output logic [VALUE_WIDTH-1:0] value,
  output logic [VALUE_WIDTH-1:0] sel_value,
  output logic                   match
);
  import ile_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

  assign sel_value = (pivot == MY_IDX) ? value : '0;

  always_ff @(posedge clk) begin
    unique case (ctl.act)
      ACT_HOLD: begin
      end
      ACT_WRITE: begin
        if (pivot == MY_IDX) value <= key;
      end
      ACT_INSERT: begin
        if (MY_IDX > pivot) value <= prev_value;
        else if (MY_IDX == pivot) value <= key;
      end
      ACT_REMOVE: begin
        if (MY_IDX >= pivot) value <= next_value;
      end
    endcase
    // Only cells below the count hold live entries.
    if (ctl.capture) match <= (MY_POS < count) && (value == key);
  end

endmodule

[sv/ile_checker.sv]
// Port-level checks for the indexed list engine and the bind that attaches them.
module ile_sva (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [1:0]        status,
  input logic signed [6:0] found_index,
  input logic              found
);
  import ile_pkg::*;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result did not follow an accepted command after three cycles");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("engine still busy while presenting a result");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("engine went busy without a command");

  a_found_consistent: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == ST_OK && found_index != NONE_IDX))
    else $error("found result carries an error status or no index");

endmodule

bind indexed_list_engine ile_sva u_ile_sva (.*);

[tb/ile_checker.sv]
// Result checker for the indexed list engine: predicts every transaction and compares results.
`timescale 1ns / 1ps
module ile_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [3:0]        kind,
  input  logic [5:0]        position,
  input  logic [31:0]       item_value,
  input  logic              done,
  input  logic [1:0]        status,
  input  logic [31:0]       read_value,
  input  logic signed [6:0] found_index,
  input  logic              found,
  input  logic [6:0]        item_count,
  input  logic              empty_res,
  output int                errors,
  output int                pending,
  output int                checked,
  output int                n_full,
  output int                n_range,
  output int                n_miss
);
  import ile_pkg::*;

  localparam int LIST_CAP   = CAPACITY_DEF;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    status_t     st;
    logic [31:0] rd;
    logic [6:0]  fidx;
    logic        fnd;
    logic [6:0]  cnt;
    logic        emp;
  } list_result_t;

  // Shadow copy of the list contents; slots at or above held_count are stale.
  logic [31:0]  held [LIST_CAP];
  int           held_count;
  list_result_t outcome_q [$];

  function automatic logic [31:0] drop_entry(int idx);
    logic [31:0] v;
    int          i;
    v = held[idx];
    for (i = idx; i + 1 < held_count; i++) held[i] = held[i + 1];
    held_count--;
    return v;
  endfunction

  function automatic list_result_t apply_cmd(logic [3:0] k, logic [5:0] p, logic [31:0] v);
    list_result_t r;
    int           hit;
    int           i;
    r.st   = ST_OK;
    r.rd   = '0;
    r.fidx = NONE_IDX;
    r.fnd  = 1'b0;
    case (k)
      K_APPEND: begin
        if (held_count >= LIST_CAP) begin
          r.st = ST_FULL;
        end else begin
          held[held_count] = v;
          held_count++;
        end
      end
      K_INSERT: begin
        // The index check is made before the full check, and the tail is refused.
        if (p >= held_count) begin
          r.st = ST_RANGE;
        end else if (held_count >= LIST_CAP) begin
          r.st = ST_FULL;
        end else begin
          for (i = held_count; i > p; i--) held[i] = held[i - 1];
          held[p] = v;
          held_count++;
        end
      end
      K_GET: begin
        if (p >= held_count) r.st = ST_RANGE;
        else r.rd = held[p];
      end
      K_SET: begin
        if (p >= held_count) r.st = ST_RANGE;
        else held[p] = v;
      end
      K_REMOVE_AT: begin
        if (p >= held_count) r.st = ST_RANGE;
        else r.rd = drop_entry(int'(p));
      end
      K_REMOVE_VALUE, K_FIRST_INDEX, K_LAST_INDEX, K_CONTAINS: begin
        hit = -1;
        for (i = 0; i < held_count; i++) begin
          if (held[i] == v && (hit < 0 || k == K_LAST_INDEX)) hit = i;
        end
        if (hit >= 0) begin
          r.fnd  = 1'b1;
          r.fidx = hit[6:0];
          if (k == K_REMOVE_VALUE) r.rd = drop_entry(hit);
        end else if (k != K_CONTAINS) begin
          r.st = ST_NOT_FOUND;
        end
      end
      K_CLEAR: held_count = 0;
      default: ;
    endcase
    r.cnt = held_count[6:0];
    r.emp = (held_count == 0);
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("ile_checker: result %0d, %s: got %0h, expected %0h", checked, what, got, want);
    end
  endtask

  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst) begin
      held_count = 0;
      errors     = 0;
      checked    = 0;
      n_full     = 0;
      n_range    = 0;
      n_miss     = 0;
      outcome_q.delete();
    end else begin
      // A result always belongs to an earlier transaction, so check before predicting.
      if (done) begin
        if (outcome_q.size() == 0) begin
          report("result with nothing outstanding", 32'd0, 32'd0);
        end else begin
          want = outcome_q.pop_front();
          checked++;
          if (status !== want.st) report("status", 32'(status), 32'(want.st));
          if (read_value !== want.rd) report("read_value", read_value, want.rd);
          if (found_index !== want.fidx) begin
            report("found_index", 32'($unsigned(found_index)), 32'(want.fidx));
          end
          if (found !== want.fnd) report("found", 32'(found), 32'(want.fnd));
          if (item_count !== want.cnt) begin
            report("item_count", 32'(item_count), 32'(want.cnt));
          end
          if (empty_res !== want.emp) report("empty_res", 32'(empty_res), 32'(want.emp));
          case (want.st)
            ST_FULL:      n_full++;
            ST_RANGE:     n_range++;
            ST_NOT_FOUND: n_miss++;
            default:      ;
          endcase
        end
      end
      if (start && !busy) outcome_q.push_back(apply_cmd(kind, position, item_value));
    end
    pending = outcome_q.size();
  end

endmodule

[tb/tb_indexed_list_engine.sv]
// Testbench top for the indexed list engine: command stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb_indexed_list_engine;
  import ile_pkg::*;

  localparam int RUN_ITEMS   = 1800;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} mode_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [3:0]        kind;
  logic [5:0]        position;
  logic [31:0]       item_value;
  logic              done;
  logic [1:0]        status;
  logic [31:0]       read_value;
  logic signed [6:0] found_index;
  logic              found;
  logic [6:0]        item_count;
  logic              empty_res;

  int errors;
  int pending;
  int checked;
  int n_full;
  int n_range;
  int n_miss;

  int          cycles = 0;
  int          issued;
  int          last_count;
  logic [31:0] value_pool [8];

  indexed_list_engine u_dut (.*);

  ile_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_indexed_list_engine: timed out after %0d cycles", cycles);
      $display("tb_indexed_list_engine: done, errors");
      $finish;
    end
  end

  // The list size steers positions; it lags one transaction, which is good enough here.
  always @(posedge clk) begin
    if (rst) last_count <= 0;
    else if (done) last_count <= int'(item_count);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [5:0] pick_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75 && last_count > 0) return 6'($urandom_range(0, last_count - 1));
    else if (r < 85) return last_count[5:0];
    else return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return value_pool[$urandom_range(0, 7)];
    else if (r < 70) return 32'h0000_0000;
    else if (r < 80) return 32'hFFFF_FFFF;
    else return $urandom();
  endfunction

  function automatic logic [3:0] pick_kind(mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        if (r < 40) return K_APPEND;
        else if (r < 65) return K_INSERT;
        else if (r < 72) return K_GET;
        else if (r < 79) return K_SET;
        else if (r < 84) return K_REMOVE_AT;
        else if (r < 88) return K_REMOVE_VALUE;
        else if (r < 91) return K_FIRST_INDEX;
        else if (r < 94) return K_LAST_INDEX;
        else if (r < 97) return K_CONTAINS;
        else return 4'($urandom_range(10, 15));
      end
      MODE_SHRINK: begin
        if (r < 30) return K_REMOVE_AT;
        else if (r < 50) return K_REMOVE_VALUE;
        else if (r < 60) return K_GET;
        else if (r < 65) return K_SET;
        else if (r < 70) return K_FIRST_INDEX;
        else if (r < 75) return K_LAST_INDEX;
        else if (r < 80) return K_CONTAINS;
        else if (r < 88) return K_APPEND;
        else if (r < 95) return K_INSERT;
        else return 4'($urandom_range(10, 15));
      end
      default: begin
        if (r < 2) return K_CLEAR;
        else if (r < 5) return 4'($urandom_range(10, 15));
        else return 4'($urandom_range(0, 8));
      end
    endcase
  endfunction

  // Drives one transaction after an optional idle gap and returns on the falling
  // edge after it was taken; start stays high so back-to-back commands need no toggle.
  task automatic issue(logic [3:0] k, logic [5:0] p, logic [31:0] v, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    kind       <= k;
    position   <= p;
    item_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    issued++;
  endtask

  initial begin : stimulus
    int    phase_len;
    int    goal;
    mode_t mode;
    bit    no_idle;
    rst        = 1'b1;
    start      = 1'b0;
    kind       = '0;
    position   = '0;
    item_value = '0;
    issued     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty list: every indexed access and every search must miss.
    issue(K_CLEAR,        6'd0,  32'h0000_0000, 0);
    issue(K_GET,          6'd0,  32'h0000_0000, pick_gap());
    issue(K_INSERT,       6'd0,  32'h1111_1111, 0);
    issue(K_REMOVE_AT,    6'd0,  32'h0000_0000, pick_gap());
    issue(K_FIRST_INDEX,  6'd63, 32'h0000_0005, 0);
    issue(K_CONTAINS,     6'd0,  32'h0000_0000, 0);
    // Build a short list with duplicated all-ones entries and one zero entry, then read, search and shrink it.
    issue(K_APPEND,       6'd0,  32'hFFFF_FFFF, pick_gap());
    issue(K_APPEND,       6'd63, 32'h0000_0000, 0);
    issue(K_INSERT,       6'd0,  32'h1234_5678, 0);
    issue(K_INSERT,       6'd3,  32'hCAFE_0001, pick_gap());
    issue(K_INSERT,       6'd2,  32'hFFFF_FFFF, 0);
    issue(K_GET,          6'd63, 32'h0000_0000, 0);
    issue(K_SET,          6'd1,  32'hA5A5_A5A5, pick_gap());
    issue(K_GET,          6'd1,  32'h0000_0000, 0);
    issue(K_LAST_INDEX,   6'd0,  32'hFFFF_FFFF, 0);
    issue(K_FIRST_INDEX,  6'd0,  32'hFFFF_FFFF, 0);
    issue(K_CONTAINS,     6'd0,  32'h0000_0000, pick_gap());
    issue(K_REMOVE_VALUE, 6'd0,  32'hFFFF_FFFF, 0);
    issue(K_REMOVE_VALUE, 6'd0,  32'h0000_DEAD, 0);
    issue(K_LAST_INDEX,   6'd0,  32'h0000_DEAD, 0);
    issue(K_REMOVE_AT,    6'd0,  32'h0000_0000, pick_gap());
    issue(4'd10,          6'd0,  32'h0000_0000, 0);
    issue(4'd15,          6'd63, 32'hFFFF_FFFF, 0);
    issue(K_SET,          6'd63, 32'h0000_0001, 0);
    issue(K_CLEAR,        6'd0,  32'h0000_0000, 0);

    // Random phases: growing phases run long enough to fill the list and hit full.
    goal = issued + RUN_ITEMS;
    while (issued < goal) begin
      mode    = mode_t'($urandom_range(0, 2));
      no_idle = ($urandom_range(0, 3) == 0);
      foreach (value_pool[i]) begin
        value_pool[i] = $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 15));
      end
      if ($urandom_range(0, 4) == 0) issue(K_CLEAR, pick_pos(), pick_value(), pick_gap());
      phase_len = (mode == MODE_GROW) ? $urandom_range(160, 260) : $urandom_range(30, 160);
      if (phase_len > goal - issued) phase_len = goal - issued;
      repeat (phase_len) begin
        issue(pick_kind(mode), pick_pos(), pick_value(), no_idle ? 0 : pick_gap());
      end
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("tb_indexed_list_engine: %0d commands issued, %0d results checked",
             issued, checked);
    $display("tb_indexed_list_engine: %0d out of range, %0d full, %0d not found",
             n_range, n_full, n_miss);
    if (errors == 0) $display("tb_indexed_list_engine: done, clean");
    else $display("tb_indexed_list_engine: done, errors");
    $finish;
  end

endmodule

[indexed_list_engine.f]
sv/ile_pkg.sv
sv/ile_cell.sv
sv/indexed_list_engine.sv
sv/ile_checker.sv
tb/ile_checker.sv
tb/tb_indexed_list_engine.sv
